// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the timer queue top level.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SDTQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SDTQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/sdtq_pkg.sv =====
// Shared types and constants for the sorted deadline timer queue.
// Depends on nothing; imported by the cell, the top level and the testbench.
package sdtq_pkg;

	localparam int MAX_TIMERS_DEF = 16;
	localparam int TIME_BITS_DEF  = 48;
	localparam int HANDLE_W       = 4;
	localparam int TIMEOUT_W      = 24;
	localparam int NOW_W          = 48;
	localparam int STATUS_W       = 3;
	localparam int HANDLE_LIMIT   = 16;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_ADJUST = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_TICK   = 2'd3
	} cmd_e;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE     = 3'd0,
		ST_EXPIRED  = 3'd1,
		ST_NONE     = 3'd2,
		ST_FULL     = 3'd3,
		ST_INACTIVE = 3'd4
	} status_e;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_INSERT
	} state_e;

	typedef struct packed {
		cmd_e                 command;
		logic [HANDLE_W-1:0]  handle_in;
		logic [TIMEOUT_W-1:0] delay_ms;
		logic [NOW_W-1:0]     now_ms;
	} request_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle_out;
		logic [STATUS_W-1:0] status;
		logic                last;
	} result_t;

	// Operation broadcast to every cell of the chain.
	typedef struct packed {
		logic ins;
		logic rem;
		logic pop;
	} cell_ctl_t;

endpackage

// ===== hw/rtl/sdtq_cell.sv =====
// One position of the sorted timer chain: holds an expiry and a handle.
// Depends on sdtq_pkg; instantiated in a row by the top level.
module sdtq_cell import sdtq_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cell_ctl_t            ctl,
	input  logic [TIME_BITS-1:0] key_expiry,
	input  logic [HANDLE_W-1:0]  key_handle,
	input  logic                 prev_valid,
	input  logic [TIME_BITS-1:0] prev_expiry,
	input  logic [HANDLE_W-1:0]  prev_handle,
	input  logic                 prev_after,
	input  logic                 prev_shift,
	input  logic                 next_valid,
	input  logic [TIME_BITS-1:0] next_expiry,
	input  logic [HANDLE_W-1:0]  next_handle,
	output logic                 valid,
	output logic [TIME_BITS-1:0] expiry,
	output logic [HANDLE_W-1:0]  handle,
	output logic                 after,
	output logic                 shift
);

	logic                 valid_q;
	logic [TIME_BITS-1:0] exp_q;
	logic [HANDLE_W-1:0]  hdl_q;
	logic                 match;

	assign valid  = valid_q;
	assign expiry = exp_q;
	assign handle = hdl_q;

	// A new key goes behind this entry only if this entry expires strictly earlier.
	always_comb begin
		after = valid_q && (exp_q < key_expiry);
		match = valid_q && (hdl_q == key_handle);
		shift = ctl.pop | (ctl.rem & (prev_shift | match));
	end

	// Occupancy bit; cleared at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.ins && !after) begin
			valid_q <= prev_after ? 1'b1 : prev_valid;
		end else if (shift) begin
			valid_q <= next_valid;
		end
	end

	// Payload: take the new key, shift right on insert, or shift left on removal.
	always_ff @(posedge clk) begin
		if (ctl.ins && !after) begin
			if (prev_after) begin
				exp_q <= key_expiry;
				hdl_q <= key_handle;
			end else begin
				exp_q <= prev_expiry;
				hdl_q <= prev_handle;
			end
		end else if (shift) begin
			exp_q <= next_expiry;
			hdl_q <= next_handle;
		end
	end

endmodule

// ===== hw/rtl/sorted_deadline_timer_queue_unit.sv =====
// Sorted deadline timer queue: a row of cells kept in ascending expiry order.
// Add and delete finish in S_EXEC; adjust removes in S_EXEC and re-inserts in S_INSERT;
// tick pops expired timers until none is due; the chain moves one entry per cycle.
// Each result strobes in the cycle after the step that makes it; the receiver cannot stall.
// Asynchronous active-low reset empties the queue and frees all handles at once.
// Depends on sdtq_pkg, sdtq_cell and assert_macros.svh.
`include "assert_macros.svh"

module sorted_deadline_timer_queue_unit import sdtq_pkg::*; #(
	parameter int MAX_TIMERS = MAX_TIMERS_DEF,
	parameter int TIME_BITS  = TIME_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  request_t request,
	output logic     result_valid,
	output result_t  result
);

	localparam int SLOTS = (MAX_TIMERS < HANDLE_LIMIT) ? MAX_TIMERS : HANDLE_LIMIT;
	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int SUM_W = ((TIME_BITS > TIMEOUT_W) ? TIME_BITS : TIMEOUT_W) + 1;

	state_e               state_q, state_d;
	cmd_e                 cmd_q;
	logic [HANDLE_W-1:0]  hdl_q;
	logic [TIME_BITS-1:0] exp_q;
	logic [TIME_BITS-1:0] now_q;
	logic [SLOTS-1:0]     in_use_q;
	logic [CNT_W-1:0]     live_q;
	logic                 result_valid_q;
	result_t              result_q;

	logic [TIME_BITS-1:0] now_t;
	logic [TIMEOUT_W-1:0] tmo_t;
	logic [SUM_W-1:0]     sum;
	logic [TIME_BITS-1:0] exp_d;

	logic [IDX_W-1:0]     free_idx;
	logic                 free_found;
	logic                 full;
	logic                 active;
	logic                 due0, due1;

	cell_ctl_t            ctl;
	logic [HANDLE_W-1:0]  key_hdl;
	logic                 res_fire;
	result_t              res_d;
	logic                 live_inc, live_dec;
	logic                 use_set, use_clr;
	logic [IDX_W-1:0]     use_idx;

	logic [SLOTS-1:0]     c_valid;
	logic [TIME_BITS-1:0] c_exp [SLOTS];
	logic [HANDLE_W-1:0]  c_hdl [SLOTS];
	logic [SLOTS-1:0]     c_after;
	logic [SLOTS-1:0]     c_shift;

	assign busy         = (state_q != S_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Expiry is now plus the timeout (zero counts as one), saturated at the top of time.
	always_comb begin
		now_t = TIME_BITS'(request.now_ms);
		tmo_t = (request.delay_ms == '0) ? TIMEOUT_W'(1) : request.delay_ms;
		sum   = SUM_W'(now_t) + SUM_W'(tmo_t);
		exp_d = (|sum[SUM_W-1:TIME_BITS]) ? '1 : sum[TIME_BITS-1:0];
	end

	// Lowest free handle.
	always_comb begin
		free_idx   = '0;
		free_found = 1'b0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				free_idx   = IDX_W'(i);
				free_found = 1'b1;
			end
		end
	end

	// Status of the queue as seen by the command in progress.
	always_comb begin
		full   = (live_q == CNT_W'(SLOTS)) || !free_found;
		active = ({1'b0, hdl_q} < (HANDLE_W + 1)'(SLOTS)) && in_use_q[hdl_q[IDX_W-1:0]];
		due0   = c_valid[0] && (c_exp[0] <= now_q);
		due1   = c_valid[1] && (c_exp[1] <= now_q);
	end

	// Sequencer: next state, chain operation, bookkeeping and result.
	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		key_hdl  = hdl_q;
		res_fire = 1'b0;
		res_d    = '0;
		live_inc = 1'b0;
		live_dec = 1'b0;
		use_set  = 1'b0;
		use_clr  = 1'b0;
		use_idx  = hdl_q[IDX_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (cmd_q) inside
					CMD_ADD: begin
						res_fire   = 1'b1;
						res_d.last = 1'b1;
						state_d    = S_IDLE;
						if (full) begin
							res_d.status = ST_FULL;
						end else begin
							ctl.ins          = 1'b1;
							key_hdl          = HANDLE_W'(free_idx);
							use_set          = 1'b1;
							use_idx          = free_idx;
							live_inc         = 1'b1;
							res_d.handle_out = HANDLE_W'(free_idx);
							res_d.status     = ST_DONE;
						end
					end
					CMD_ADJUST, CMD_DELETE: begin
						res_d.handle_out = hdl_q;
						res_d.last       = 1'b1;
						if (!active) begin
							res_fire     = 1'b1;
							res_d.status = ST_INACTIVE;
							state_d      = S_IDLE;
						end else begin
							ctl.rem  = 1'b1;
							live_dec = 1'b1;
							if (cmd_q == CMD_DELETE) begin
								use_clr      = 1'b1;
								res_fire     = 1'b1;
								res_d.status = ST_DONE;
								state_d      = S_IDLE;
							end else begin
								state_d = S_INSERT;
							end
						end
					end
					CMD_TICK: begin
						res_fire = 1'b1;
						if (due0) begin
							ctl.pop          = 1'b1;
							live_dec         = 1'b1;
							use_clr          = 1'b1;
							use_idx          = c_hdl[0][IDX_W-1:0];
							res_d.handle_out = c_hdl[0];
							res_d.status     = ST_EXPIRED;
							res_d.last       = !due1;
							state_d          = due1 ? S_EXEC : S_IDLE;
						end else begin
							res_d.status = ST_NONE;
							res_d.last   = 1'b1;
							state_d      = S_IDLE;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_INSERT: begin
				// Second half of an adjust: place the re-armed handle.
				ctl.ins          = 1'b1;
				live_inc         = 1'b1;
				res_fire         = 1'b1;
				res_d.handle_out = hdl_q;
				res_d.status     = ST_DONE;
				res_d.last       = 1'b1;
				state_d          = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			in_use_q       <= '0;
			live_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			result_valid_q <= res_fire;
			if (use_set) begin
				in_use_q[use_idx] <= 1'b1;
			end else if (use_clr) begin
				in_use_q[use_idx] <= 1'b0;
			end
			if (live_inc) begin
				live_q <= live_q + CNT_W'(1);
			end else if (live_dec) begin
				live_q <= live_q - CNT_W'(1);
			end
		end
	end

	// Command fields captured on transfer, and the result register.
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_q <= request.command;
			hdl_q <= request.handle_in;
			exp_q <= exp_d;
			now_q <= now_t;
		end
		if (res_fire) begin
			result_q <= res_d;
		end
	end

	// The chain of cells, position 0 holding the earliest expiry.
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		logic                 p_valid, p_after, p_shift, n_valid;
		logic [TIME_BITS-1:0] p_exp, n_exp;
		logic [HANDLE_W-1:0]  p_hdl, n_hdl;

		if (i == 0) begin : g_head
			assign p_valid = 1'b0;
			assign p_exp   = '0;
			assign p_hdl   = '0;
			assign p_after = 1'b1;
			assign p_shift = 1'b0;
		end else begin : g_body
			assign p_valid = c_valid[i-1];
			assign p_exp   = c_exp[i-1];
			assign p_hdl   = c_hdl[i-1];
			assign p_after = c_after[i-1];
			assign p_shift = c_shift[i-1];
		end

		if (i == SLOTS - 1) begin : g_tail
			assign n_valid = 1'b0;
			assign n_exp   = '0;
			assign n_hdl   = '0;
		end else begin : g_mid
			assign n_valid = c_valid[i+1];
			assign n_exp   = c_exp[i+1];
			assign n_hdl   = c_hdl[i+1];
		end

		sdtq_cell #(
			.TIME_BITS(TIME_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.key_expiry (exp_q),
			.key_handle (key_hdl),
			.prev_valid (p_valid),
			.prev_expiry(p_exp),
			.prev_handle(p_hdl),
			.prev_after (p_after),
			.prev_shift (p_shift),
			.next_valid (n_valid),
			.next_expiry(n_exp),
			.next_handle(n_hdl),
			.valid      (c_valid[i]),
			.expiry     (c_exp[i]),
			.handle     (c_hdl[i]),
			.after      (c_after[i]),
			.shift      (c_shift[i])
		);
	end

	// Occupied cells always match the live count.
	`SDTQ_ASSERT_NOW(a_live_cells, clk, arst_n, 1'b1, CNT_W'($countones(c_valid)) == live_q, "cells")
	// Between commands the number of allocated handles equals the live count.
	`SDTQ_ASSERT_NOW(a_live_handles, clk, arst_n, state_q == S_IDLE, CNT_W'($countones(in_use_q)) == live_q, "handles")
	// A result marked last leaves the block ready for the next transfer.
	`SDTQ_ASSERT_NOW(a_last_idle, clk, arst_n, result_valid_q && result_q.last, state_q == S_IDLE, "busy")
	// An accepted transfer always makes the block busy in the next cycle.
	`SDTQ_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy, "transfer accepted, not busy")

endmodule

// ===== sim/sorted_deadline_timer_queue_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the sorted deadline timer queue, predictor included.
// Depends on sdtq_pkg and sorted_deadline_timer_queue_unit.

module sorted_deadline_timer_queue_unit_tb;
	import sdtq_pkg::*;

	localparam int SLOTS = (MAX_TIMERS_DEF < HANDLE_LIMIT) ? MAX_TIMERS_DEF : HANDLE_LIMIT;
	localparam logic [NOW_W-1:0] TIME_TOP = '1;
	localparam int ITEMS_PER_PHASE = 43;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int END_DRAIN = 40;
	localparam int MAX_GAP = 60;

	typedef struct {
		request_t req;
		int       reps;
		bit       typed;
		result_t  want;
	} stim_row_t;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	request_t request;
	logic     result_valid;
	result_t  result;

	// Typed expectation travelling with a directed command.
	bit       typed_valid;
	result_t  typed_result;

	// Model of the timer list, updated at each accepted command.
	logic [NOW_W-1:0]    list_expiry [SLOTS];
	logic [HANDLE_W-1:0] list_handle [SLOTS];
	int                  live_total;
	bit                  handle_busy [SLOTS];
	result_t             awaited_results [$];

	logic [NOW_W-1:0] wall_ms;
	int mismatch_count;
	int quiet_cycles;
	int results_seen;
	int full_seen;
	int inactive_seen;
	int longest_burst;
	int cmd_count [4];

	sorted_deadline_timer_queue_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.result_valid (result_valid),
		.result       (result)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic void log_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("Mismatch at %0t: %s", $time, msg);
		end
	endfunction

	function automatic void await_result(int h, status_e st, bit is_last);
		result_t r;
		r.handle_out = h[HANDLE_W-1:0];
		r.status = st;
		r.last = is_last;
		awaited_results.push_back(r);
	endfunction

	// Expiry is now plus timeout, zero timeout counting as one, held at the top of time.
	function automatic logic [NOW_W-1:0] deadline(logic [NOW_W-1:0] now, logic [TIMEOUT_W-1:0] t);
		logic [NOW_W:0] sum;
		sum = {1'b0, now} + {{(NOW_W + 1 - TIMEOUT_W){1'b0}}, (t == '0) ? TIMEOUT_W'(1) : t};
		return sum[NOW_W] ? TIME_TOP : sum[NOW_W-1:0];
	endfunction

	function automatic void list_remove(int p);
		if (p < live_total) begin
			for (int i = p; i + 1 < live_total; i++) begin
				list_expiry[i] = list_expiry[i + 1];
				list_handle[i] = list_handle[i + 1];
			end
			live_total--;
		end
	endfunction

	// A new entry goes ahead of every entry with the same expiry.
	function automatic void list_insert(int h, logic [NOW_W-1:0] e);
		int pos;
		pos = 0;
		if (live_total < SLOTS) begin
			while (pos < live_total && list_expiry[pos] < e) pos++;
			for (int i = live_total; i > pos; i--) begin
				list_expiry[i] = list_expiry[i - 1];
				list_handle[i] = list_handle[i - 1];
			end
			list_expiry[pos] = e;
			list_handle[pos] = h[HANDLE_W-1:0];
			live_total++;
		end
	endfunction

	// Applies one command to the model and queues the results it must produce.
	function automatic void advance_timer_list(request_t r);
		int slot;
		int pos;
		int n;
		int eh;
		bit more;
		slot = -1;
		case (r.command) inside
			CMD_ADD: begin
				for (int i = SLOTS - 1; i >= 0; i--) begin
					if (!handle_busy[i]) slot = i;
				end
				if (slot < 0 || live_total >= SLOTS) begin
					await_result(0, ST_FULL, 1'b1);
				end else begin
					handle_busy[slot] = 1'b1;
					list_insert(slot, deadline(r.now_ms, r.delay_ms));
					await_result(slot, ST_DONE, 1'b1);
				end
			end
			CMD_ADJUST, CMD_DELETE: begin
				if (r.handle_in >= SLOTS || !handle_busy[r.handle_in]) begin
					await_result(r.handle_in, ST_INACTIVE, 1'b1);
				end else begin
					pos = live_total;
					for (int i = live_total - 1; i >= 0; i--) begin
						if (list_handle[i] == r.handle_in) pos = i;
					end
					list_remove(pos);
					if (r.command == CMD_ADJUST) begin
						list_insert(r.handle_in, deadline(r.now_ms, r.delay_ms));
					end else begin
						handle_busy[r.handle_in] = 1'b0;
					end
					await_result(r.handle_in, ST_DONE, 1'b1);
				end
			end
			default: begin
				n = 0;
				more = live_total > 0 && list_expiry[0] <= r.now_ms;
				while (more) begin
					eh = list_handle[0];
					handle_busy[eh] = 1'b0;
					list_remove(0);
					n++;
					more = live_total > 0 && n < HANDLE_LIMIT && list_expiry[0] <= r.now_ms;
					await_result(eh, ST_EXPIRED, !more);
				end
				if (n == 0) begin
					await_result(0, ST_NONE, 1'b1);
				end
				if (n > longest_burst) longest_burst = n;
			end
		endcase
	endfunction

	// Sample both transfers at the clock edge and compare results in order.
	always @(posedge clk) begin
		if (arst_n) begin
			quiet_cycles++;
			if (start && !busy) begin
				quiet_cycles = 0;
				cmd_count[int'(request.command)]++;
				advance_timer_list(request);
				if (typed_valid) begin
					void'(awaited_results.pop_back());
					awaited_results.push_back(typed_result);
				end
			end
			if (result_valid) begin
				quiet_cycles = 0;
				results_seen++;
				if (result.status == ST_FULL) full_seen++;
				if (result.status == ST_INACTIVE) inactive_seen++;
				if (awaited_results.size() == 0) begin
					log_mismatch($sformatf("unexpected result handle %0d status %0d last %0d",
						result.handle_out, result.status, result.last));
				end else if (result !== awaited_results[0]) begin
					log_mismatch($sformatf(
						"expected handle %0d status %0d last %0d, got %0d %0d %0d",
						awaited_results[0].handle_out, awaited_results[0].status,
						awaited_results[0].last, result.handle_out, result.status,
						result.last));
					void'(awaited_results.pop_front());
				end else begin
					void'(awaited_results.pop_front());
				end
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	function automatic stim_row_t make_row(cmd_e c, int h, logic [TIMEOUT_W-1:0] t,
		logic [NOW_W-1:0] now, int reps, bit typed, int want_h, status_e want_st);
		stim_row_t row;
		row.req.command = c;
		row.req.handle_in = h[HANDLE_W-1:0];
		row.req.delay_ms = t;
		row.req.now_ms = now;
		row.reps = reps;
		row.typed = typed;
		row.want.handle_out = want_h[HANDLE_W-1:0];
		row.want.status = want_st;
		row.want.last = 1'b1;
		return row;
	endfunction

	// Mostly well-formed traffic on live handles, with jumps and noise in time.
	function automatic request_t random_request();
		request_t r;
		int pick;
		int live_handles [$];
		pick = $urandom_range(99);
		if (pick < 4) begin
			wall_ms = {16'($urandom), $urandom};
		end else if (pick < 7) begin
			wall_ms = TIME_TOP - NOW_W'($urandom_range(400));
		end else begin
			wall_ms = wall_ms + NOW_W'($urandom_range(60));
		end
		r.now_ms = ($urandom_range(99) < 8) ? {16'($urandom), $urandom} : wall_ms;
		pick = $urandom_range(99);
		if (pick < 80) begin
			r.delay_ms = TIMEOUT_W'($urandom_range(300));
		end else if (pick < 90) begin
			r.delay_ms = TIMEOUT_W'($urandom);
		end else begin
			r.delay_ms = '0;
		end
		pick = $urandom_range(99);
		if (pick < 35) begin
			r.command = CMD_ADD;
		end else if (pick < 65) begin
			r.command = CMD_TICK;
		end else if (pick < 82) begin
			r.command = CMD_ADJUST;
		end else begin
			r.command = CMD_DELETE;
		end
		for (int i = 0; i < SLOTS; i++) begin
			if (handle_busy[i]) live_handles.push_back(i);
		end
		r.handle_in = HANDLE_W'($urandom_range(15));
		if ((r.command == CMD_ADJUST || r.command == CMD_DELETE) &&
			live_handles.size() > 0 && $urandom_range(99) < 85) begin
			r.handle_in = HANDLE_W'(live_handles[$urandom_range(live_handles.size() - 1)]);
		end
		return r;
	endfunction

	// Hold a command on the bus until the block takes it.
	task automatic send_command(request_t r, bit typed, result_t want);
		request <= r;
		typed_valid <= typed;
		typed_result <= want;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic idle_gap(int pct);
		int gap;
		gap = 0;
		if ($urandom_range(99) < pct) begin
			start <= 1'b0;
			do begin
				@(posedge clk);
				gap++;
			end while ($urandom_range(99) < pct && gap < MAX_GAP);
		end
	endtask

	// Stop sending until every queued result has come back.
	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (awaited_results.size() != 0);
	endtask

	initial begin
		stim_row_t directed [$];
		int idle_pct [3];
		result_t no_want;
		idle_pct = '{0, 76, 10};
		no_want = '0;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		typed_valid = 1'b0;
		typed_result = '0;
		live_total = 0;
		wall_ms = '0;
		foreach (handle_busy[i]) handle_busy[i] = 1'b0;
		foreach (cmd_count[i]) cmd_count[i] = 0;

		// Errors on an empty block, zero timeout, saturation, equal-expiry order.
		directed.push_back(make_row(CMD_TICK, 0, 0, 0, 1, 1, 0, ST_NONE));
		directed.push_back(make_row(CMD_DELETE, 0, 0, 0, 1, 1, 0, ST_INACTIVE));
		directed.push_back(make_row(CMD_ADJUST, 15, 5, 0, 1, 1, 15, ST_INACTIVE));
		directed.push_back(make_row(CMD_ADD, 0, 0, 0, 1, 1, 0, ST_DONE));
		directed.push_back(make_row(CMD_TICK, 0, 0, 0, 1, 1, 0, ST_NONE));
		directed.push_back(make_row(CMD_TICK, 0, 0, 1, 1, 1, 0, ST_EXPIRED));
		directed.push_back(make_row(CMD_ADD, 0, 24'hFF_FFFF, TIME_TOP, 1, 1, 0, ST_DONE));
		directed.push_back(make_row(CMD_ADD, 0, 5, 48'hFFFF_FFFF_FFFA, 1, 1, 1, ST_DONE));
		directed.push_back(make_row(CMD_ADD, 0, 1, 10, 1, 1, 2, ST_DONE));
		directed.push_back(make_row(CMD_ADJUST, 2, 20, 10, 1, 1, 2, ST_DONE));
		directed.push_back(make_row(CMD_ADJUST, 1, 0, 100, 1, 1, 1, ST_DONE));
		directed.push_back(make_row(CMD_ADD, 0, 91, 10, 1, 1, 3, ST_DONE));
		directed.push_back(make_row(CMD_TICK, 0, 0, 200, 1, 0, 0, ST_DONE));
		directed.push_back(make_row(CMD_TICK, 0, 0, 48'hFFFF_FFFF_FFFE, 1, 1, 0, ST_NONE));
		directed.push_back(make_row(CMD_TICK, 0, 0, TIME_TOP, 1, 1, 0, ST_EXPIRED));
		// Fill every handle, then overflow, free and reuse.
		directed.push_back(make_row(CMD_ADD, 0, 1000, 300, SLOTS, 0, 0, ST_DONE));
		directed.push_back(make_row(CMD_ADD, 0, 1, 300, 1, 1, 0, ST_FULL));
		directed.push_back(make_row(CMD_DELETE, 15, 0, 300, 1, 0, 0, ST_DONE));
		directed.push_back(make_row(CMD_DELETE, 3, 0, 300, 1, 0, 0, ST_DONE));
		directed.push_back(make_row(CMD_ADJUST, 7, 0, 1299, 1, 0, 0, ST_DONE));
		directed.push_back(make_row(CMD_ADD, 0, 0, 1299, 1, 0, 0, ST_DONE));
		directed.push_back(make_row(CMD_TICK, 0, 0, 1299, 1, 1, 0, ST_NONE));
		directed.push_back(make_row(CMD_ADD, 0, 0, 1299, 1, 0, 0, ST_DONE));
		directed.push_back(make_row(CMD_TICK, 0, 0, 1300, 1, 0, 0, ST_DONE));
		directed.push_back(make_row(CMD_DELETE, 5, 0, 1300, 1, 1, 5, ST_INACTIVE));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			repeat (directed[i].reps) begin
				send_command(directed[i].req, directed[i].typed, directed[i].want);
			end
		end
		drain_results();
		wall_ms = 48'd2000;

		// Random traffic in phases of different sender pacing.
		foreach (idle_pct[p]) begin
			repeat (ITEMS_PER_PHASE) begin
				send_command(random_request(), 1'b0, no_want);
				idle_gap(idle_pct[p]);
			end
			drain_results();
		end

		repeat (END_DRAIN) @(posedge clk);
		$display("Coverage: %0d commands (add %0d, adjust %0d, delete %0d, tick %0d)",
			cmd_count[0] + cmd_count[1] + cmd_count[2] + cmd_count[3],
			cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3]);
		$display("Coverage: %0d results, %0d full, %0d inactive, largest expiry burst %0d",
			results_seen, full_seen, inactive_seen, longest_burst);
		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
